### design/vialu_pkg.sv
package vialu_pkg;

	// Number of vector registers and element width
	localparam int NUM_VREGS = 32;
	localparam int ELEM_W    = 32;

	// Item modes
	localparam logic [1:0] MODE_EXEC  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	// funct6 operation codes
	localparam logic [5:0] OP_VADD     = 6'b000000;
	localparam logic [5:0] OP_VSUB     = 6'b000010;
	localparam logic [5:0] OP_VAND     = 6'b001001;
	localparam logic [5:0] OP_VOR      = 6'b001010;
	localparam logic [5:0] OP_VXOR     = 6'b001011;
	localparam logic [5:0] OP_VRGATHER = 6'b001100;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;	// capture the item and read its source rows
		logic exec;	// compute, write back and register the result
	} cmd_t;

endpackage

### design/vialu_ctrl.sv
module vialu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output vialu_pkg::cmd_t     cmd
);
	import vialu_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	// Advance from idle to execute on an accepted item, and back to idle in the next cycle
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Drive busy and the datapath commands
	assign busy     = (state_q == ST_EXEC);
	assign cmd.load = start && (state_q == ST_IDLE);
	assign cmd.exec = (state_q == ST_EXEC);

endmodule

### design/vialu_rf.sv
module vialu_rf #(
	parameter int ROW_W = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [4:0]       rd_addr_a,
	input  logic [4:0]       rd_addr_b,
	output logic [ROW_W-1:0] rd_data_a,
	output logic [ROW_W-1:0] rd_data_b,
	input  logic             wr_en,
	input  logic [4:0]       wr_addr,
	input  logic [ROW_W-1:0] wr_data
);
	import vialu_pkg::*;

	logic [ROW_W-1:0]     mem_q [NUM_VREGS];
	logic [NUM_VREGS-1:0] row_vld_q;
	logic [ROW_W-1:0]     rd_a_q;
	logic [ROW_W-1:0]     rd_b_q;
	logic                 vld_a_q;
	logic                 vld_b_q;

	// Register storage: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem_q[rd_addr_a];
			rd_b_q <= mem_q[rd_addr_b];
		end
	end

	// Track which rows have been written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			vld_a_q   <= 1'b0;
			vld_b_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_a_q <= row_vld_q[rd_addr_a];
				vld_b_q <= row_vld_q[rd_addr_b];
			end
		end
	end

	// An unwritten row reads as zero
	assign rd_data_a = vld_a_q ? rd_a_q : '0;
	assign rd_data_b = vld_b_q ? rd_b_q : '0;

endmodule

### design/vialu_dp.sv
module vialu_dp #(
	parameter int LANES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vialu_pkg::cmd_t     cmd,
	input  logic [1:0]          mode,
	input  logic [5:0]          op_code,
	input  logic [4:0]          dest_reg,
	input  logic [4:0]          src1_reg,
	input  logic [4:0]          src2_reg,
	input  logic [1:0]          element_index,
	input  logic [31:0]         write_value,
	output logic                done,
	output logic [31:0]         read_value,
	output logic                illegal
);
	import vialu_pkg::*;

	localparam int ROW_W = LANES * ELEM_W;
	localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int IW    = (LW > 2) ? LW : 2;

	logic [1:0]        mode_q;
	logic [5:0]        op_q;
	logic [4:0]        dest_q;
	logic [1:0]        idx_q;
	logic [31:0]       wval_q;

	logic [4:0]        rd_addr_a;
	logic [ROW_W-1:0]  row_a;
	logic [ROW_W-1:0]  row_b;
	logic [31:0]       a_lane [LANES];
	logic [31:0]       b_lane [LANES];
	logic [31:0]       r_lane [LANES];
	logic [ROW_W-1:0]  alu_row;
	logic [ROW_W-1:0]  ins_row;
	logic              op_legal;
	logic [IW-1:0]     lane_wide;
	logic [LW-1:0]     lane_sel;
	logic              lane_ok;
	logic              wr_en;
	logic [ROW_W-1:0]  wr_data;
	logic [31:0]       rval;

	logic              done_q;
	logic [31:0]       read_value_q;
	logic              illegal_q;

	// Hold the item fields for the execute cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			op_q   <= op_code;
			dest_q <= dest_reg;
			idx_q  <= element_index;
			wval_q <= write_value;
		end
	end

	// Port A reads vs1 for an instruction, otherwise the element's register
	assign rd_addr_a = (mode == MODE_EXEC) ? src1_reg : dest_reg;

	vialu_rf #(
		.ROW_W (ROW_W)
	) u_rf (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (cmd.load),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (src2_reg),
		.rd_data_a (row_a),
		.rd_data_b (row_b),
		.wr_en     (wr_en),
		.wr_addr   (dest_q),
		.wr_data   (wr_data)
	);

	// Split the rows into lanes
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			a_lane[i] = row_a[i*ELEM_W +: ELEM_W];
			b_lane[i] = row_b[i*ELEM_W +: ELEM_W];
		end
	end

	// Lane ALU and gather crossbar; vs2 is the left operand
	always_comb begin
		op_legal = 1'b1;
		for (int i = 0; i < LANES; i++) begin
			r_lane[i] = '0;
		end
		case (op_q)
			OP_VADD: begin
				for (int i = 0; i < LANES; i++) r_lane[i] = b_lane[i] + a_lane[i];
			end
			OP_VSUB: begin
				for (int i = 0; i < LANES; i++) r_lane[i] = b_lane[i] - a_lane[i];
			end
			OP_VAND: begin
				for (int i = 0; i < LANES; i++) r_lane[i] = b_lane[i] & a_lane[i];
			end
			OP_VOR: begin
				for (int i = 0; i < LANES; i++) r_lane[i] = b_lane[i] | a_lane[i];
			end
			OP_VXOR: begin
				for (int i = 0; i < LANES; i++) r_lane[i] = b_lane[i] ^ a_lane[i];
			end
			OP_VRGATHER: begin
				for (int i = 0; i < LANES; i++) begin
					r_lane[i] = (a_lane[i] < 32'(LANES)) ? b_lane[a_lane[i][LW-1:0]] : '0;
				end
			end
			default: begin
				op_legal = 1'b0;
			end
		endcase
	end

	// Element lane select; lanes beyond the vector are dropped
	assign lane_wide = IW'(idx_q);
	assign lane_sel  = lane_wide[LW-1:0];
	assign lane_ok   = (32'(idx_q) < 32'(LANES));

	// Pack the ALU row and the row with one element replaced
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			alu_row[i*ELEM_W +: ELEM_W] = r_lane[i];
			ins_row[i*ELEM_W +: ELEM_W] = (LW'(i) == lane_sel) ? wval_q : a_lane[i];
		end
	end

	// Write back and form the result
	always_comb begin
		wr_en   = 1'b0;
		wr_data = alu_row;
		rval    = '0;
		if (cmd.exec) begin
			if (mode_q == MODE_EXEC) begin
				wr_en = op_legal;
			end else if (mode_q == MODE_WRITE) begin
				wr_en   = lane_ok;
				wr_data = ins_row;
			end else if (mode_q == MODE_READ && lane_ok) begin
				rval = a_lane[lane_sel];
			end
		end
	end

	// Register the result for one strobe cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			read_value_q <= rval;
			illegal_q    <= (mode_q == MODE_EXEC) && !op_legal;
		end
	end

	assign done       = done_q;
	assign read_value = read_value_q;
	assign illegal    = illegal_q;

endmodule

### design/vector_integer_alu_regfile.sv
// Vector integer ALU with a register file of 32 vector registers, each of
// LANES 32-bit elements.
// Input: an item is taken at a rising edge where start is high and busy is
// low. mode selects an instruction (funct6 in op_code, vd/vs1/vs2), a single
// element write (dest_reg, element_index, write_value) or a single element
// read (dest_reg, element_index).
// Output: done is high for exactly one cycle per item; read_value and
// illegal are valid in that cycle only. The receiver cannot hold results off.
// Timing: an item accepted at edge N reads both source rows from the
// register storage at that edge, executes and writes back in the next cycle
// (busy high), and shows done in the cycle after that. No new item is
// taken while busy, set by the registered read of the register storage
// followed by the write-back cycle; the next one can be accepted in the
// cycle that shows done.
// Reset: arst_n clears the controller and marks every vector register as
// unwritten, so all registers read as zero at once; no clearing pass.
module vector_integer_alu_regfile #(
	parameter int LANES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [5:0]  op_code,
	input  logic [4:0]  dest_reg,
	input  logic [4:0]  src1_reg,
	input  logic [4:0]  src2_reg,
	input  logic [1:0]  element_index,
	input  logic [31:0] write_value,
	output logic        done,
	output logic [31:0] read_value,
	output logic        illegal
);
	import vialu_pkg::*;

	cmd_t cmd;

	// Sequence each item
	vialu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Register file, lane ALU and result registers
	vialu_dp #(
		.LANES (LANES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.mode          (mode),
		.op_code       (op_code),
		.dest_reg      (dest_reg),
		.src1_reg      (src1_reg),
		.src2_reg      (src2_reg),
		.element_index (element_index),
		.write_value   (write_value),
		.done          (done),
		.read_value    (read_value),
		.illegal       (illegal)
	);

endmodule

### design/vialu_chk.sv
module vialu_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] read_value,
	input logic        illegal
);

	// An accepted item makes the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after an accepted item");

	// A result follows the busy cycle and never overlaps it
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe outside the cycle after busy");

	// Every busy period ends with a result
	a_busy_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// An illegal instruction returns no read data
	a_illegal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && illegal) |-> (read_value == 32'd0))
		else $error("read data with an illegal instruction");

endmodule

bind vector_integer_alu_regfile vialu_chk u_chk (.*);
